// ----- sv/gzob_pkg.sv -----
package gzob_pkg;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_INIT,
		ST_POP,
		ST_POP_WAIT,
		ST_CELL,
		ST_NBR,
		ST_NBR_WAIT,
		ST_NBR_UPD,
		ST_RES_RD,
		ST_RES_WAIT
	} gzob_state_t;

	localparam logic [7:0] DIST_INF = 8'd255;
	localparam logic [7:0] COST_CAP = 8'd254;
	localparam logic [6:0] OUT_CAP  = 7'd127;
	localparam logic [2:0] CFG_ROWS = 3'd0;
	localparam logic [2:0] CFG_COLS = 3'd1;

	// Stored arrow codes, which are also the neighbor step order.
	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	typedef struct packed {
		logic load_wr;
		logic ptr_clr;
		logic clr_start;
		logic clr_step;
		logic init;
		logic pop;
		logic cell_rd;
		logic cell_latch;
		logic nbr_start;
		logic nbr_rd;
		logic nbr_upd;
		logic nbr_next;
		logic res_rd;
		logic res_latch;
	} gzob_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic dq_empty;
		logic cell_skip;
		logic nbr_valid;
		logic nbr_last;
	} gzob_sts_t;

endpackage

// ----- sv/grid_zero_one_bfs_min_cost_top.sv -----
// Cells load at one item per cycle while the block is loading; after the last item
// the distances of all MAX_ROWS*MAX_COLS cells are cleared, an init step follows,
// and the search pops each entry (pop, read, latch) and visits each neighbor (read,
// wait, update inside the grid; only a check outside it) until the deque runs empty.
// Throughput: one grid at a time; cells wait during a search and while a finished
// result finds the output register still full. Reset: asynchronous, active low.
module grid_zero_one_bfs_min_cost_top
	import gzob_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int DEQUE_DEPTH = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cell_dir,
	input  logic       last_cell,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] min_cost
);

	gzob_cmd_t cmd;
	gzob_sts_t sts;

	// The controller sequences load, clear, search and result delivery. A result
	// sits in an output register, so the next grid can load while it waits.
	gzob_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last_cell),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// The datapath holds the arrow, distance and deque memories.
	gzob_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DEQUE_DEPTH(DEQUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cell_dir(cell_dir), .cmd(cmd), .sts(sts),
		.min_cost(min_cost)
	);

`ifndef NO_ASSERTIONS
	// A result stays offered until it is taken.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");
	// A held result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(min_cost))
		else $error("min_cost changed while stalled");
`endif

endmodule

// ----- sv/gzob_ctrl.sv -----
module gzob_ctrl
	import gzob_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  gzob_sts_t sts,
	output gzob_cmd_t cmd
);

	gzob_state_t state_q, state_d;
	logic out_full_q;
	logic slot_free;

	assign slot_free = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// The output register holds one finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.res_latch) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (in_valid && in_last) state_d = ST_CLEAR;
			ST_CLEAR:    if (sts.clr_done) state_d = ST_INIT;
			ST_INIT:     state_d = ST_POP;
			ST_POP:      state_d = sts.dq_empty ? ST_RES_RD : ST_POP_WAIT;
			ST_POP_WAIT: state_d = ST_CELL;
			ST_CELL:     state_d = sts.cell_skip ? ST_POP : ST_NBR;
			ST_NBR:      begin
				if (sts.nbr_valid) state_d = ST_NBR_WAIT;
				else if (sts.nbr_last) state_d = ST_POP;
			end
			ST_NBR_WAIT: state_d = ST_NBR_UPD;
			ST_NBR_UPD:  state_d = sts.nbr_last ? ST_POP : ST_NBR;
			ST_RES_RD:   state_d = ST_RES_WAIT;
			ST_RES_WAIT: if (slot_free) state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load_wr = in_valid;
				cmd.clr_start = in_valid && in_last;
			end
			ST_CLEAR:    cmd.clr_step = 1'b1;
			ST_INIT:     cmd.init = 1'b1;
			ST_POP:      cmd.pop = !sts.dq_empty;
			ST_POP_WAIT: cmd.cell_rd = 1'b1;
			ST_CELL:     begin
				cmd.cell_latch = 1'b1;
				cmd.nbr_start = 1'b1;
			end
			ST_NBR:      begin
				cmd.nbr_rd = sts.nbr_valid;
				cmd.nbr_next = !sts.nbr_valid;
			end
			ST_NBR_UPD:  begin
				cmd.nbr_upd = 1'b1;
				cmd.nbr_next = 1'b1;
			end
			ST_RES_RD:   cmd.res_rd = 1'b1;
			ST_RES_WAIT: begin
				cmd.res_rd = 1'b1;
				cmd.res_latch = slot_free;
				cmd.ptr_clr = slot_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/gzob_dp.sv -----
module gzob_dp
	import gzob_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int DEQUE_DEPTH = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic [2:0] cell_dir,
	input  gzob_cmd_t  cmd,
	output gzob_sts_t  sts,
	output logic [6:0] min_cost
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int QW = $clog2(DEQUE_DEPTH);
	localparam int XW = RW + CW;
	localparam logic [8:0] MR = 9'(MAX_ROWS);
	localparam logic [8:0] MC = 9'(MAX_COLS);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);
	localparam logic [QW:0] QDEPTH = (QW + 1)'(DEQUE_DEPTH);
	localparam logic [QW-1:0] QLAST = QW'(DEQUE_DEPTH - 1);

	logic [6:0] rows_reg_q, cols_reg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg_q <= 7'd64;
			cols_reg_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS) rows_reg_q <= cfg_data;
			else if (cfg_index == CFG_COLS) cols_reg_q <= cfg_data;
		end
	end

	logic [8:0] rows_e, cols_e;
	always_comb begin
		rows_e = {2'b0, rows_reg_q};
		if (rows_e == 9'd0) rows_e = 9'd1;
		else if (rows_e > MR) rows_e = MR;
		cols_e = {2'b0, cols_reg_q};
		if (cols_e == 9'd0) cols_e = 9'd1;
		else if (cols_e > MC) cols_e = MC;
	end

	logic [17:0] cells;
	assign cells = rows_e * cols_e;

	// Memories. A deque word holds cost, address, row and column, so that a
	// popped cell needs no division to find its place in the grid.
	logic [1:0] arrow_mem [DEPTH];
	logic [7:0] dist_mem [DEPTH];
	logic [XW+AW+7:0] qx_mem [DEQUE_DEPTH];

	logic [AW:0] load_ptr_q;
	logic [AW:0] clr_ptr_q;
	logic [QW-1:0] head_q;
	logic [QW:0] count_q;
	logic [XW+AW+7:0] qx_rd_q;
	logic [1:0] arrow_rd_q;
	logic [7:0] dist_rd_q;

	// Current cell.
	logic [AW-1:0] cur_addr_q;
	logic [RW-1:0] cur_r_q;
	logic [CW-1:0] cur_c_q;
	logic [7:0] cur_cost_q;
	logic [1:0] cur_arrow_q;
	logic [2:0] k_q;
	logic [6:0] min_cost_q;

	logic [AW-1:0] pop_addr;
	logic [RW-1:0] pop_r;
	logic [CW-1:0] pop_c;
	assign pop_addr = qx_rd_q[XW+AW-1:XW];
	assign pop_r = qx_rd_q[XW-1:CW];
	assign pop_c = qx_rd_q[CW-1:0];

	// Neighbor for current k.
	logic signed [9:0] nr, nc;
	logic nbr_in;
	logic [AW-1:0] nbr_addr;
	logic [7:0] ncost;
	logic [8:0] ncost_w;
	always_comb begin
		nr = $signed({2'b0, 8'(cur_r_q)});
		nc = $signed({2'b0, 8'(cur_c_q)});
		case (k_q[1:0])
			DIR_RIGHT: nc = nc + 10'sd1;
			DIR_LEFT:  nc = nc - 10'sd1;
			DIR_DOWN:  nr = nr + 10'sd1;
			default:   nr = nr - 10'sd1;
		endcase
		nbr_in = !nr[9] && !nc[9] && (nr < $signed({1'b0, rows_e}))
			&& (nc < $signed({1'b0, cols_e})) && !k_q[2];
		case (k_q[1:0])
			DIR_RIGHT: nbr_addr = cur_addr_q + AW'(1);
			DIR_LEFT:  nbr_addr = cur_addr_q - AW'(1);
			DIR_DOWN:  nbr_addr = cur_addr_q + AW'(cols_e);
			default:   nbr_addr = cur_addr_q - AW'(cols_e);
		endcase
		ncost_w = {1'b0, cur_cost_q} + {8'd0, (k_q[1:0] != cur_arrow_q)};
		ncost = (ncost_w > {1'b0, COST_CAP}) ? COST_CAP : ncost_w[7:0];
	end

	logic [AW-1:0] nbr_addr_s1;
	logic [7:0] ncost_s1;
	logic [RW-1:0] nbr_r_s1;
	logic [CW-1:0] nbr_c_s1;
	logic push_front_s1;

	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = nbr_addr;
		if (cmd.cell_rd) rd_addr = pop_addr;
		if (cmd.res_rd) rd_addr = AW'(cells - 18'd1);
	end

	// Deque pointers wrap at the deque depth.
	logic dq_full;
	logic push_en;
	logic [QW-1:0] head_inc, head_dec, push_slot;
	logic [QW:0] back_sum;
	assign dq_full = (count_q == QDEPTH);
	assign push_en = cmd.nbr_upd && (dist_rd_q > ncost_s1) && !dq_full;
	always_comb begin
		head_inc = (head_q == QLAST) ? '0 : head_q + QW'(1);
		head_dec = (head_q == '0) ? QLAST : head_q - QW'(1);
		back_sum = {1'b0, head_q} + count_q;
		if (back_sum >= QDEPTH) back_sum = back_sum - QDEPTH;
		push_slot = push_front_s1 ? head_dec : back_sum[QW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) arrow_mem[load_ptr_q[AW-1:0]] <= cell_dir[1:0] - 2'd1;
		if (cmd.clr_step && !clr_ptr_q[AW]) dist_mem[clr_ptr_q[AW-1:0]] <= DIST_INF;
		else if (cmd.init) dist_mem[0] <= 8'd0;
		else if (cmd.nbr_upd && (dist_rd_q > ncost_s1)) dist_mem[nbr_addr_s1] <= ncost_s1;
		dist_rd_q <= dist_mem[rd_addr];
		arrow_rd_q <= arrow_mem[rd_addr];
		if (cmd.init) qx_mem[0] <= '0;
		else if (push_en) qx_mem[push_slot] <= {ncost_s1, nbr_addr_s1, nbr_r_s1, nbr_c_s1};
		if (cmd.pop) qx_rd_q <= qx_mem[head_q];
		if (cmd.nbr_rd) begin
			nbr_addr_s1 <= nbr_addr;
			ncost_s1 <= ncost;
			nbr_r_s1 <= nr[RW-1:0];
			nbr_c_s1 <= nc[CW-1:0];
			push_front_s1 <= (ncost <= cur_cost_q);
		end
		if (cmd.cell_latch) begin
			cur_addr_q <= pop_addr;
			cur_cost_q <= qx_rd_q[XW+AW+7:XW+AW];
			cur_r_q <= pop_r;
			cur_c_q <= pop_c;
			cur_arrow_q <= arrow_rd_q;
		end
		if (cmd.res_latch) min_cost_q <= (dist_rd_q > {1'b0, OUT_CAP}) ? OUT_CAP : dist_rd_q[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			clr_ptr_q <= '0;
			head_q <= '0;
			count_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.load_wr) begin
				load_ptr_q <= (load_ptr_q + 1'b1 >= DEPTH_V) ? '0 : load_ptr_q + 1'b1;
			end
			if (cmd.ptr_clr) load_ptr_q <= '0;
			if (cmd.clr_start) clr_ptr_q <= '0;
			else if (cmd.clr_step && !clr_ptr_q[AW]) clr_ptr_q <= clr_ptr_q + 1'b1;
			if (cmd.init) begin
				head_q <= '0;
				count_q <= (QW + 1)'(1);
			end else if (cmd.pop) begin
				head_q <= head_inc;
				count_q <= count_q - 1'b1;
			end else if (push_en) begin
				count_q <= count_q + 1'b1;
				if (push_front_s1) head_q <= head_dec;
			end
			if (cmd.nbr_start) k_q <= '0;
			else if (cmd.nbr_next) k_q <= k_q + 3'd1;
		end
	end

	assign sts.clr_done = clr_ptr_q[AW] || (clr_ptr_q == DEPTH_V - 1'b1 && cmd.clr_step);
	assign sts.dq_empty = (count_q == '0);
	assign sts.cell_skip = ({{(18-AW){1'b0}}, pop_addr} >= cells);
	assign sts.nbr_valid = nbr_in;
	assign sts.nbr_last = (k_q[1:0] == DIR_UP) || k_q[2];
	assign min_cost = min_cost_q;

endmodule

// ----- bench/gzob_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both item channels, keeps its own copy of
// the arrow grid and predicts each minimum cost by a 0-1 breadth-first search.
module gzob_checker
	import gzob_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] cell_dir,
	input  logic       last_cell,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [6:0] min_cost,
	output int         pending,
	output int         fails,
	output int         searches
);

	localparam int GRID_MAX = 64;
	localparam int CELL_MAX = GRID_MAX * GRID_MAX;
	localparam int RING_SIZE = 16384;

	logic [1:0]  arrow_mem [0:CELL_MAX-1];
	logic [7:0]  dist_mem [0:CELL_MAX-1];
	int          ring_cell [0:RING_SIZE-1];
	logic [7:0]  ring_cost [0:RING_SIZE-1];
	int          ring_head;
	int          ring_count;
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	int          load_ptr;
	logic [6:0]  cost_q[$];

	function automatic int clamp_size(logic [6:0] v);
		if (v == 0)
			return 1;
		if (v > GRID_MAX)
			return GRID_MAX;
		return int'(v);
	endfunction

	function automatic void ring_push(logic [7:0] cost, int node_addr, bit at_front);
		int slot;
		if (ring_count >= RING_SIZE)
			return;
		if (at_front) begin
			ring_head = (ring_head == 0) ? RING_SIZE - 1 : ring_head - 1;
			slot = ring_head;
		end else begin
			slot = (ring_head + ring_count) % RING_SIZE;
		end
		ring_cost[slot] = cost;
		ring_cell[slot] = node_addr;
		ring_count++;
	endfunction

	// Least number of arrow changes from the top-left to the bottom-right cell.
	function automatic logic [6:0] fewest_turns();
		int rows;
		int cols;
		int cells;
		int node;
		int r;
		int c;
		int nr;
		int nc;
		int nxt;
		int cost;
		int ncost;
		int step_r [0:3];
		int step_c [0:3];
		rows = clamp_size(rows_reg);
		cols = clamp_size(cols_reg);
		cells = rows * cols;
		step_r = '{0, 0, 1, -1};
		step_c = '{1, -1, 0, 0};
		for (int i = 0; i < CELL_MAX; i++)
			dist_mem[i] = DIST_INF;
		ring_head = 0;
		ring_count = 0;
		dist_mem[0] = 8'd0;
		ring_push(8'd0, 0, 1'b0);
		while (ring_count != 0) begin
			node = ring_cell[ring_head];
			cost = int'(ring_cost[ring_head]);
			ring_head = (ring_head + 1) % RING_SIZE;
			ring_count--;
			if (node >= cells)
				continue;
			r = node / cols;
			c = node % cols;
			for (int k = 0; k < 4; k++) begin
				nr = r + step_r[k];
				nc = c + step_c[k];
				if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
					continue;
				nxt = nr * cols + nc;
				ncost = cost + ((k != int'(arrow_mem[node])) ? 1 : 0);
				if (ncost > int'(COST_CAP))
					ncost = int'(COST_CAP);
				if (int'(dist_mem[nxt]) > ncost) begin
					dist_mem[nxt] = 8'(ncost);
					ring_push(8'(ncost), nxt, ncost <= cost);
				end
			end
		end
		if (dist_mem[cells - 1] > 8'(OUT_CAP))
			return OUT_CAP;
		return dist_mem[cells - 1][6:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [2:0] code;
		if (!arst_n) begin
			rows_reg <= 7'd64;
			cols_reg <= 7'd64;
			load_ptr = 0;
			cost_q.delete();
			pending <= 0;
			fails <= 0;
			searches <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROWS)
					rows_reg <= cfg_data;
				else if (cfg_index == CFG_COLS)
					cols_reg <= cfg_data;
			end
			if (out_valid && out_ready) begin
				if (cost_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, min_cost);
					fails <= fails + 1;
				end else begin
					if (min_cost !== cost_q[0]) begin
						$display("%0t: min_cost mismatch, expected %0d, actual %0d",
							$time, cost_q[0], min_cost);
						fails <= fails + 1;
					end
					cost_q.delete(0);
				end
				searches <= searches + 1;
			end
			if (in_valid && in_ready) begin
				// Codes outside 1..4 wrap: the stored arrow is the code minus one.
				code = cell_dir - 3'd1;
				arrow_mem[load_ptr] = code[1:0];
				load_ptr = (load_ptr + 1) % CELL_MAX;
				if (last_cell) begin
					cost_q.insert(cost_q.size(), fewest_turns());
					load_ptr = 0;
				end
			end
			pending <= cost_q.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import gzob_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] cell_dir;
	logic       last_cell;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] min_cost;
	int         pending;
	int         fails;
	int         searches;

	// Stimulus bookkeeping. The arrow store is only ever read where some
	// grid has already written it, so the longest load so far is tracked.
	int  longest_load;
	int  items_sent;
	int  grid_rows;
	int  grid_cols;
	bit  no_gaps;
	bit  hold_request;
	int  hold_left;

	grid_zero_one_bfs_min_cost_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cell_dir (cell_dir),
		.last_cell(last_cell),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost (min_cost)
	);

	gzob_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cell_dir (cell_dir),
		.last_cell(last_cell),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost (min_cost),
		.pending  (pending),
		.fails    (fails),
		.searches (searches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Generous upper bound: every search includes a full clearing pass of the
	// distance memory, plus long receiver stalls, all well under this time.
	initial begin
		#200ms;
		$display("Timeout after %0t with %0d results outstanding", $time, pending);
		$display("Mismatches found");
		$finish;
	end

	// Mostly no gap, sometimes a short one, rarely a long stretch.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(99);
		if (no_gaps || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic int clamp_size(int v);
		if (v == 0)
			return 1;
		if (v > 64)
			return 64;
		return v;
	endfunction

	// Receiver side: random stalls, with one long hold-off on request so that
	// the block finishes a search, keeps its result and stops taking cells.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 6000;
			out_ready <= 1'b0;
		end else if (no_gaps) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= (gap_length() == 0);
		end
	end

	// Offers one cell and returns once it has been accepted. Ready is sampled
	// mid-cycle, so the decision never races the block's own edge updates.
	task automatic send_cell(logic [2:0] code, logic last);
		int gap;
		bit taken;
		gap = gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_dir <= code;
		last_cell <= last;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic reg_write(logic [2:0] index, logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Registers change only with nothing in flight: the sender waits for every
	// result, then waits further to let the block settle.
	task automatic set_grid(logic [6:0] rows, logic [6:0] cols);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (30) @(posedge clk);
		reg_write(CFG_ROWS, rows);
		reg_write(CFG_COLS, cols);
		cfg_we <= 1'b0;
		@(posedge clk);
		grid_rows = clamp_size(int'(rows));
		grid_cols = clamp_size(int'(cols));
	endtask

	// Most arrows are legal codes; a few use the wrapping codes 0 and 5..7.
	function automatic logic [2:0] pick_arrow();
		if ($urandom_range(19) == 0)
			return 3'($urandom_range(7));
		return 3'($urandom_range(4, 1));
	endfunction

	// Sends one grid of the current size. A short grid is sent only where the
	// cells it leaves out were already written; a long one loads one to four spare
	// cells past the end of the grid.
	task automatic send_grid(bit allow_odd);
		int cells;
		int count;
		int roll;
		cells = grid_rows * grid_cols;
		count = cells;
		roll = $urandom_range(9);
		if (allow_odd && roll == 0 && longest_load >= cells && cells > 1)
			count = $urandom_range(cells - 1, 1);
		else if (allow_odd && roll == 1)
			count = cells + $urandom_range(4, 1);
		for (int i = 0; i < count; i++)
			send_cell(pick_arrow(), i == count - 1);
		if (count > longest_load)
			longest_load = count;
	endtask

	initial begin
		int phase;
		int odd_size;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = 7'd0;
		in_valid = 1'b0;
		cell_dir = 3'd1;
		last_cell = 1'b0;
		hold_request = 1'b0;
		no_gaps = 1'b0;
		longest_load = 0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Indexes above the two registers must be ignored.
		for (int idx = 2; idx < 8; idx++)
			reg_write(3'(idx), 7'h7F);
		cfg_we <= 1'b0;
		set_grid(7'd1, 7'd1);
		send_cell(3'd3, 1'b1);                  // single cell costs nothing
		set_grid(7'd0, 7'd0);                   // zero sizes act as one
		send_cell(3'd0, 1'b1);
		set_grid(7'd2, 7'd3);
		for (int i = 0; i < 6; i++)              // codes 2 to 7, wrapping ones too
			send_cell(3'(i + 2), i == 5);
		send_cell(3'd1, 1'b0);                  // short grid reuses old arrows
		send_cell(3'd3, 1'b1);
		set_grid(7'd3, 7'd3);
		for (int i = 0; i < 9; i++)
			send_cell((i % 2 == 0) ? 3'd4 : 3'd2, i == 8);

		// Random part: mostly small grids, sometimes a full-length row or
		// column, register values beyond the maximum now and then.
		phase = 0;
		while (items_sent < 1700) begin
			phase++;
			no_gaps = ($urandom_range(4) == 0);
			case ($urandom_range(9))
				0: set_grid(7'd64, 7'($urandom_range(2, 1)));
				1: set_grid(7'($urandom_range(2, 1)), 7'd127);
				2: set_grid(7'($urandom_range(127, 65)), 7'd1);
				3: set_grid(7'd1, 7'd1);
				default: set_grid(7'($urandom_range(8, 1)), 7'($urandom_range(8, 1)));
			endcase
			if (phase == 5)
				hold_request = 1'b1;
			for (int g = $urandom_range(4, 1); g > 0; g--)
				send_grid(1'b1);
		end
		in_valid <= 1'b0;

		// One larger grid near the end exercises a deeper search.
		set_grid(7'd16, 7'd16);
		send_grid(1'b0);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d cells in %0d grids over %0d register settings,", items_sent,
			searches, phase + 5);
		$display("with random gaps, a long receiver stall and odd-length grids.");
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
sv/gzob_pkg.sv
sv/gzob_ctrl.sv
sv/gzob_dp.sv
sv/grid_zero_one_bfs_min_cost_top.sv
bench/gzob_checker.sv
bench/testbench.sv
